/* rtl/core/lad_pkg.sv */
// shared constants and coded-pair encoder for the lookahead decoder
`default_nettype none

package lad_pkg;

    localparam int HIST_W   = 4;
    localparam int FILL_W   = 3;
    localparam int DIST_W   = 4;
    localparam int MSG_W    = 13;
    localparam int SR_W     = 5;

    localparam int LOOKAHEAD_DEF        = 4;
    localparam int MAX_MESSAGE_BITS_DEF = 4096;

    localparam logic [MSG_W-1:0] MSG_BITS_RESET = 13'd4096;
    localparam logic [SR_W-1:0]  GEN_A          = 5'h19;
    localparam logic [SR_W-1:0]  GEN_B          = 5'h17;

    // bit1 from GEN_A, bit0 from GEN_B
    function automatic logic [1:0] lad_encode(input logic [SR_W-1:0] sr);
        lad_encode = {^(sr & GEN_A), ^(sr & GEN_B)};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/conv_k5_lookahead_decoder_top.sv */
// top level of the rate 1/2 k=5 hard-decision lookahead decoder
// the completing beat is registered in the input register, its result in the output register
// throughput: one pair per cycle; the search reads history updated by the previous pair
// the output register decouples the sides; input ready also falls while a result is stalled
// reset (synchronous, active low) clears history, window, counters, valids; message_bits -> 4096
`default_nettype none

module conv_k5_lookahead_decoder_top
    import lad_pkg::*;
#(
    parameter int LOOKAHEAD        = LOOKAHEAD_DEF,
    parameter int MAX_MESSAGE_BITS = MAX_MESSAGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MSG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_coded_pair,
    input  logic              i_start_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_data_bit,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_final_bit
);

    localparam int CNT_W = $clog2(MAX_MESSAGE_BITS + 1);
    localparam int CMP_W = (CNT_W > MSG_W) ? CNT_W : MSG_W;
    localparam int WIN_W = 2 * LOOKAHEAD;

    logic [MSG_W-1:0]  r_msg_bits;
    logic              r_in_vld;
    logic [1:0]        r_in_pair;
    logic              r_in_start;
    logic [HIST_W-1:0] r_hist, n_hist;
    logic [WIN_W-1:0]  r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_active, n_active;
    logic              r_out_vld;
    logic              r_out_bit;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_final;

    logic [HIST_W-1:0] hist_e;
    logic [FILL_W-1:0] fill_e;
    logic [CNT_W-1:0]  count_e;
    logic              active_e;
    logic [WIN_W-1:0]  win_now;
    logic              full;
    logic              produce;
    logic              out_free;
    logic              move;
    logic              in_take;
    logic              dec_bit;
    logic [DIST_W-1:0] dec_dist;
    logic [CMP_W-1:0]  lim;
    logic [CMP_W-1:0]  count_inc;
    logic              fin;

    assign hist_e   = r_in_start ? '0 : r_hist;
    assign fill_e   = r_in_start ? '0 : r_fill;
    assign count_e  = r_in_start ? '0 : r_count;
    assign active_e = r_in_start | r_active;

    always_comb begin
        for (int k = 0; k < LOOKAHEAD; k++) begin
            if (fill_e == FILL_W'(k)) begin
                win_now[2*k +: 2] = r_in_pair;
            end else begin
                win_now[2*k +: 2] = r_in_start ? 2'b00 : r_win[2*k +: 2];
            end
        end
    end

    lad_search #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_lad_search (
        .i_history  (hist_e),
        .i_window   (win_now),
        .o_bit      (dec_bit),
        .o_distance (dec_dist)
    );

    always_comb begin
        if (r_msg_bits == '0) begin
            lim = CMP_W'(1);
        end else if (CMP_W'(r_msg_bits) > CMP_W'(MAX_MESSAGE_BITS)) begin
            lim = CMP_W'(MAX_MESSAGE_BITS);
        end else begin
            lim = CMP_W'(r_msg_bits);
        end
    end

    assign count_inc = CMP_W'(count_e) + CMP_W'(1);
    assign fin       = (count_inc >= lim);

    assign full     = (fill_e == FILL_W'(LOOKAHEAD - 1));
    assign produce  = r_in_vld & active_e & full;
    assign out_free = ~r_out_vld | i_out_ready;
    assign move     = r_in_vld & (~produce | out_free);
    assign in_take  = i_in_valid & o_in_ready;

    assign o_in_ready  = ~r_in_vld | move;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_hist   = r_hist;
        n_win    = r_win;
        n_fill   = r_fill;
        n_count  = r_count;
        n_active = r_active;
        if (move && active_e) begin
            if (full) begin
                n_hist   = {hist_e[HIST_W-2:0], dec_bit};
                n_win    = win_now >> 2;
                n_fill   = fill_e;
                n_count  = CNT_W'(count_inc);
                n_active = ~fin;
            end else begin
                n_hist   = hist_e;
                n_win    = win_now;
                n_fill   = fill_e + FILL_W'(1);
                n_count  = count_e;
                n_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_bits <= MSG_BITS_RESET;
            r_in_vld   <= 1'b0;
            r_hist     <= '0;
            r_win      <= '0;
            r_fill     <= '0;
            r_count    <= '0;
            r_active   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_msg_bits <= i_cfg_data;
            end
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            r_hist   <= n_hist;
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_active <= n_active;
            if (produce && move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pair  <= i_coded_pair;
            r_in_start <= i_start_req;
        end
        if (produce && move) begin
            r_out_bit   <= dec_bit;
            r_out_dist  <= dec_dist;
            r_out_final <= fin;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_data_bit  = r_out_bit;
    assign o_distance  = r_out_dist;
    assign o_final_bit = r_out_final;

endmodule

`default_nettype wire

/* rtl/core/lad_search.sv */
// hypothesis search: re-encode every hypothesis, pick minimum hamming distance
`default_nettype none

module lad_search
    import lad_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
) (
    input  logic [HIST_W-1:0]      i_history,
    input  logic [2*LOOKAHEAD-1:0] i_window,
    output logic                   o_bit,
    output logic [DIST_W-1:0]      o_distance
);

    localparam int NHYP = 1 << LOOKAHEAD;

    typedef struct packed {
        logic              first;
        logic [DIST_W-1:0] score;
    } t_node;

    t_node tree [LOOKAHEAD+1][NHYP];

    always_comb begin
        logic [SR_W-1:0]      sr;
        logic [LOOKAHEAD-1:0] hyp;
        logic [1:0]           x;
        logic [DIST_W-1:0]    d;
        for (int l = 0; l <= LOOKAHEAD; l++) begin
            for (int i = 0; i < NHYP; i++) begin
                tree[l][i] = '0;
            end
        end
        // leaf distances
        for (int h = 0; h < NHYP; h++) begin
            hyp = LOOKAHEAD'(h);
            sr  = {1'b0, i_history};
            d   = '0;
            for (int k = 0; k < LOOKAHEAD; k++) begin
                sr = {sr[SR_W-2:0], hyp[LOOKAHEAD-1-k]};
                x  = lad_encode(sr) ^ i_window[2*k +: 2];
                d  = d + DIST_W'(x[0]) + DIST_W'(x[1]);
            end
            tree[0][h].first = hyp[LOOKAHEAD-1];
            tree[0][h].score = d;
        end
        // min tree, left (lower hypothesis) wins ties
        for (int l = 1; l <= LOOKAHEAD; l++) begin
            for (int i = 0; i < (NHYP >> l); i++) begin
                if (tree[l-1][2*i+1].score < tree[l-1][2*i].score) begin
                    tree[l][i] = tree[l-1][2*i+1];
                end else begin
                    tree[l][i] = tree[l-1][2*i];
                end
            end
        end
    end

    assign o_bit      = tree[LOOKAHEAD][0].first;
    assign o_distance = tree[LOOKAHEAD][0].score;

endmodule

`default_nettype wire

/* rtl/core/lad_checker.sv */
// port-level assertion checker for the lookahead decoder, bound to the top level
`default_nettype none

module lad_checker
    import lad_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_data_bit,
    input wire logic [DIST_W-1:0] o_distance,
    input wire logic              o_final_bit
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_bit)
            && $stable(o_distance) && $stable(o_final_bit))
        else $error("result beat changed while stalled");

    // distance never exceeds the coded bits in the window
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance <= DIST_W'(2 * LOOKAHEAD))
        else $error("distance out of range");

    // an empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with output register empty");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind conv_k5_lookahead_decoder_top lad_checker #(
    .LOOKAHEAD (LOOKAHEAD)
) u_lad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_data_bit  (o_data_bit),
    .o_distance  (o_distance),
    .o_final_bit (o_final_bit)
);

`default_nettype wire
